[rtl/cprgd_pkg.sv]
// Shared types and command codes for the rectangle and glyph drawing engine.
package cprgd_pkg;

  typedef enum logic [2:0] {
    KIND_PLOT  = 3'd0,
    KIND_FILL  = 3'd1,
    KIND_RECT  = 3'd2,
    KIND_GLYPH = 3'd3,
    KIND_READ  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    OP_SPAN,
    OP_GLYPH,
    OP_READ
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_RDWAIT,
    ST_RDOUT
  } state_e;

  localparam int unsigned CoordW = 16;
  localparam int unsigned GlyphW = 64;
  localparam int unsigned GlyphRows = 8;

  // One classified job: op, outside flag, inclusive box (clipped for rects), colour, glyph bits.
  typedef struct packed {
    op_e               op;
    logic              outside;
    logic [CoordW-1:0] x0;
    logic [CoordW-1:0] y0;
    logic [CoordW-1:0] x1;
    logic [CoordW-1:0] y1;
    logic [7:0]        color;
    logic [GlyphW-1:0] glyph;
  } job_t;

endpackage

[rtl/clipped_pixel_rect_glyph_drawer_top.sv]
// Top level of the clipped pixel, rectangle and glyph drawing engine.
// The back end finishes one job before it takes the next; all pixel writes go
// through the frame store's single write port.
// Reset (rst_ni, async low) clears the queue and FSM; the frame store is not cleared.
module clipped_pixel_rect_glyph_drawer_top #(
  parameter int unsigned FrameWidth  = 320,
  parameter int unsigned FrameHeight = 200,
  parameter int unsigned PixelBits   = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind_i,
  input  logic [15:0] first_x_i,
  input  logic [15:0] first_y_i,
  input  logic [15:0] second_x_i,
  input  logic [15:0] second_y_i,
  input  logic [7:0]  pixel_value_i,
  input  logic [63:0] glyph_bits_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_value_o
);

  // The front end clips each item into a job and queues it; dropped items
  // never reach the back end.
  cprgd_pkg::job_t job;
  logic            job_valid, job_ready;

  cprgd_front #(
    .FrameWidth(FrameWidth), .FrameHeight(FrameHeight), .PixelBits(PixelBits)
  ) u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .kind_i, .first_x_i, .first_y_i,
    .second_x_i, .second_y_i, .pixel_value_i, .glyph_bits_i,
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  // The back end draws one pixel per cycle and answers reads in order.
  cprgd_back #(
    .FrameWidth(FrameWidth), .FrameHeight(FrameHeight), .PixelBits(PixelBits)
  ) u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_ready_o(job_ready),
    .job_i(job), .out_valid, .out_ready, .read_value_o
  );

endmodule

[rtl/cprgd_front.sv]
// Front end: accepts commands, orders and clips coordinates, queues jobs.
module cprgd_front #(
  parameter int unsigned FrameWidth  = 320,
  parameter int unsigned FrameHeight = 200,
  parameter int unsigned PixelBits   = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 kind_i,
  input  logic [15:0]                first_x_i,
  input  logic [15:0]                first_y_i,
  input  logic [15:0]                second_x_i,
  input  logic [15:0]                second_y_i,
  input  logic [7:0]                 pixel_value_i,
  input  logic [63:0]                glyph_bits_i,
  output logic                       job_valid_o,
  input  logic                       job_ready_i,
  output cprgd_pkg::job_t            job_o
);

  localparam logic [15:0] LastX = 16'(FrameWidth - 1);
  localparam logic [15:0] LastY = 16'(FrameHeight - 1);
  localparam logic [7:0]  PixMask = 8'((64'd1 << PixelBits) - 64'd1);

  // Two-entry queue.
  cprgd_pkg::job_t q_mem_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;

  cprgd_pkg::job_t job_d;
  logic            keep;
  logic [15:0]     lx, hx, ly, hy;

  always_comb begin
    lx = (first_x_i > second_x_i) ? second_x_i : first_x_i;
    hx = (first_x_i > second_x_i) ? first_x_i : second_x_i;
    ly = (first_y_i > second_y_i) ? second_y_i : first_y_i;
    hy = (first_y_i > second_y_i) ? first_y_i : second_y_i;
    job_d = '0;
    job_d.color = pixel_value_i & PixMask;
    job_d.glyph = glyph_bits_i;
    job_d.outside = (first_x_i > LastX) || (first_y_i > LastY);
    keep = 1'b1;
    case (kind_i)
      cprgd_pkg::KIND_PLOT: begin
        job_d.op = cprgd_pkg::OP_SPAN;
        job_d.x0 = first_x_i; job_d.x1 = first_x_i;
        job_d.y0 = first_y_i; job_d.y1 = first_y_i;
        keep = !job_d.outside;
      end
      cprgd_pkg::KIND_FILL: begin
        job_d.op = cprgd_pkg::OP_SPAN;
        job_d.x1 = LastX;
        job_d.y1 = LastY;
      end
      cprgd_pkg::KIND_RECT: begin
        job_d.op = cprgd_pkg::OP_SPAN;
        job_d.x0 = lx; job_d.y0 = ly;
        job_d.x1 = (hx > LastX) ? LastX : hx;
        job_d.y1 = (hy > LastY) ? LastY : hy;
        keep = (lx <= LastX) && (ly <= LastY);
      end
      cprgd_pkg::KIND_GLYPH: begin
        job_d.op = cprgd_pkg::OP_GLYPH;
        job_d.x0 = first_x_i; job_d.y0 = first_y_i;
        keep = !job_d.outside;
      end
      cprgd_pkg::KIND_READ: begin
        job_d.op = cprgd_pkg::OP_READ;
        job_d.x0 = first_x_i; job_d.y0 = first_y_i;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready    = (cnt_q != 2'd2);
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = q_mem_q[rd_ptr_q];

  logic push, pop;
  assign push = in_valid && in_ready && keep;
  assign pop  = job_valid_o && job_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= job_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
    end
  end

endmodule

[rtl/cprgd_back.sv]
// Back end: walks each drawing job one pixel per cycle over the frame store and answers reads.
module cprgd_back #(
  parameter int unsigned FrameWidth  = 320,
  parameter int unsigned FrameHeight = 200,
  parameter int unsigned PixelBits   = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  output logic            job_ready_o,
  input  cprgd_pkg::job_t job_i,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      read_value_o
);

  localparam int unsigned Depth = FrameWidth * FrameHeight;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam logic [15:0] LastX = 16'(FrameWidth - 1);
  localparam logic [15:0] LastY = 16'(FrameHeight - 1);

  logic [PixelBits-1:0] mem_q [Depth];
  logic [PixelBits-1:0] rd_q;

  cprgd_pkg::state_e state_q, state_d;
  cprgd_pkg::job_t   job_q;
  logic [15:0]       x_q, y_q;
  logic [AddrW-1:0]  row_base_q, addr_q;
  logic [2:0]        gc_q, gr_q;
  logic              zero_q;

  logic          is_glyph, last_col, last_row, bit_on, we;
  logic [7:0]    row_byte;
  logic [5:0]    gshift;

  assign is_glyph = (job_q.op == cprgd_pkg::OP_GLYPH);
  assign gshift   = 6'(({3'd0, 3'd7 - gr_q}) << 3);
  assign row_byte = 8'(job_q.glyph >> gshift);
  assign bit_on   = is_glyph ? row_byte[3'd7 - gc_q] : 1'b1;
  assign last_col = is_glyph ? ((gc_q == 3'd7) || (x_q == LastX)) : (x_q == job_q.x1);
  assign last_row = is_glyph ? ((gr_q == 3'd7) || (y_q == LastY)) : (y_q == job_q.y1);
  assign we       = (state_q == cprgd_pkg::ST_RUN) && bit_on;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cprgd_pkg::ST_IDLE:
        if (job_valid_i) begin
          state_d = (job_i.op == cprgd_pkg::OP_READ) ? cprgd_pkg::ST_RDWAIT
                                                     : cprgd_pkg::ST_RUN;
        end
      cprgd_pkg::ST_RUN:
        if (last_col && last_row) state_d = cprgd_pkg::ST_IDLE;
      cprgd_pkg::ST_RDWAIT: state_d = cprgd_pkg::ST_RDOUT;
      cprgd_pkg::ST_RDOUT:
        if (out_ready) state_d = cprgd_pkg::ST_IDLE;
      default: state_d = cprgd_pkg::ST_IDLE;
    endcase
  end

  // The store output register holds the read pixel from the end of the wait
  // state on, since the address and the store do not change until the next job.
  always_comb begin
    job_ready_o = (state_q == cprgd_pkg::ST_IDLE);
    out_valid   = (state_q == cprgd_pkg::ST_RDOUT);
    read_value_o = zero_q ? 8'd0 : 8'(rd_q);
  end

  logic [AddrW-1:0] start_base, start_addr;
  assign start_base = AddrW'(job_i.y0 * FrameWidth);
  assign start_addr = start_base + AddrW'(job_i.x0);

  always_ff @(posedge clk_i) begin
    if (we) mem_q[addr_q] <= job_q.color[PixelBits-1:0];
    rd_q <= mem_q[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == cprgd_pkg::ST_IDLE && job_valid_i) begin
      job_q      <= job_i;
      x_q        <= job_i.x0;
      y_q        <= job_i.y0;
      row_base_q <= start_base;
      addr_q     <= start_addr;
      gc_q       <= 3'd0;
      gr_q       <= 3'd0;
      zero_q     <= job_i.outside;
    end else if (state_q == cprgd_pkg::ST_RUN) begin
      if (last_col) begin
        x_q        <= job_q.x0;
        y_q        <= y_q + 16'd1;
        gc_q       <= 3'd0;
        gr_q       <= gr_q + 3'd1;
        row_base_q <= row_base_q + AddrW'(FrameWidth);
        addr_q     <= row_base_q + AddrW'(FrameWidth) + AddrW'(job_q.x0);
      end else begin
        x_q    <= x_q + 16'd1;
        gc_q   <= gc_q + 3'd1;
        addr_q <= addr_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= cprgd_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

endmodule

[rtl/cprgd_checker.sv]
// Port level checker for the drawing engine, bound to the top level.
module cprgd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] read_value_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(read_value_o))
    else $error("result item dropped or changed while stalled");

  a_out_pulse_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready |=> !out_valid)
    else $error("result item repeated after delivery");

  a_no_out_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid)
    else $error("result item invented after reset");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !in_ready |=> in_valid)
    else $error("input item withdrawn while stalled");

endmodule

bind clipped_pixel_rect_glyph_drawer_top cprgd_checker u_checker (
  .clk_i, .rst_ni, .in_valid, .in_ready, .out_valid, .out_ready, .read_value_o
);
